FILE: design/cst_pkg.sv
package cst_pkg;

	localparam int NUM_SEMS_DEF = 32;
	localparam int WAITERS_DEF  = 64;

	localparam int MODE_W   = 2;
	localparam int IDX_W    = 5;
	localparam int PID_BITS = 16;
	localparam int INIT_W   = 15;
	localparam int COUNT_BITS = 16;
	localparam int STATUS_W = 3;

	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE  = 2'd0,
		MODE_DESTROY = 2'd1,
		MODE_WAIT    = 2'd2,
		MODE_SIGNAL  = 2'd3
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_FREE   = 3'd1,
		ST_INACTIVE  = 3'd2,
		ST_FULL      = 3'd3,
		ST_NO_WAITER = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EVAL = 3'b010,
		S_OUT  = 3'b100
	} state_t;

endpackage

FILE: design/cst_req_if.sv
interface cst_req_if;
	import cst_pkg::*;

	logic                valid;
	logic                ready;
	logic [MODE_W-1:0]   mode;
	logic [IDX_W-1:0]    sem_index;
	logic [PID_BITS-1:0] caller_pid;
	logic [INIT_W-1:0]   initial_count;

	modport source (output valid, mode, sem_index, caller_pid, initial_count, input ready);
	modport sink (input valid, mode, sem_index, caller_pid, initial_count, output ready);

endinterface

FILE: design/cst_rsp_if.sv
interface cst_rsp_if;
	import cst_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    created_index;
	logic                must_block;
	logic                wake_valid;
	logic [PID_BITS-1:0] woken_pid;

	modport source (output valid, status, created_index, must_block, wake_valid, woken_pid,
		input ready);
	modport sink (input valid, status, created_index, must_block, wake_valid, woken_pid,
		output ready);

endinterface

FILE: design/counting_semaphore_table_top.sv
// Counting semaphore table with per-entry waiter queues.
// Request channel (req): mode, sem_index, caller_pid, initial_count; one transaction
// per operation (create, destroy, wait, signal). Response channel (rsp): exactly one
// transaction per request with status, created_index, must_block, wake_valid and
// woken_pid; fields that do not apply read as zero.
// Timing: a request is taken in the idle cycle, the entry's count and occupancy row are
// read from memory at that edge, the next cycle decides and writes back (and reads the
// waiter id for a signal), and then the S_OUT state loads the response register. The
// next request is taken in the cycle after the response is loaded, so the block takes
// no new request before the last one is through, as set by the read-modify-write
// of the count and occupancy memories.
// Stall: the response register holds its transaction while rsp.ready is low; a following
// request still runs until its result is ready, then waits for the register to free.
// Reset: clears all active flags and marks every occupancy row empty through per-row
// valid flags, so no clearing pass is needed; the block takes requests right away.
// Waiter ids live in a memory with no reset; only ids from occupied slots are ever used.
module counting_semaphore_table_top #(
	parameter int NUM_SEMS        = cst_pkg::NUM_SEMS_DEF,
	parameter int WAITERS_PER_SEM = cst_pkg::WAITERS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	cst_req_if.sink   req,
	cst_rsp_if.source rsp
);
	import cst_pkg::*;

	localparam int SEM_W     = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int AW        = ((SEM_W > IDX_W) ? SEM_W : IDX_W) + 1;
	localparam int SLOT_W    = (WAITERS_PER_SEM > 1) ? $clog2(WAITERS_PER_SEM) : 1;
	localparam int PID_DEPTH = NUM_SEMS * WAITERS_PER_SEM;
	localparam int PA_W      = $clog2(PID_DEPTH);

	state_t state_q;

	logic [NUM_SEMS-1:0] active_q;
	logic [NUM_SEMS-1:0] occ_vld_q;

	logic signed [COUNT_BITS-1:0] count_mem [NUM_SEMS];
	logic [WAITERS_PER_SEM-1:0]   occ_mem [NUM_SEMS];
	logic [PID_BITS-1:0]          pid_mem [PID_DEPTH];

	logic           acc;
	logic [AW-1:0]  idx_ext;
	logic [SEM_W-1:0] addr_in;
	logic           in_range;

	mode_t                      mode_s1;
	logic [SEM_W-1:0]           addr_s1;
	logic                       in_range_s1;
	logic [PID_BITS-1:0]        pid_s1;
	logic [INIT_W-1:0]          init_s1;
	logic signed [COUNT_BITS-1:0] count_s1;
	logic [WAITERS_PER_SEM-1:0] occ_s1;
	logic                       occ_vld_s1;

	logic [WAITERS_PER_SEM-1:0] row;
	logic                       free_found;
	logic [SLOT_W-1:0]          free_slot;
	logic                       busy_found;
	logic [SLOT_W-1:0]          busy_slot;
	logic                       sem_found;
	logic [SEM_W-1:0]           sem_free;
	logic                       is_active;
	logic signed [COUNT_BITS-1:0] cnt_dec;
	logic signed [COUNT_BITS-1:0] cnt_inc;

	logic                         cnt_we;
	logic [SEM_W-1:0]             cnt_wa;
	logic signed [COUNT_BITS-1:0] cnt_wd;
	logic                         occ_we;
	logic [WAITERS_PER_SEM-1:0]   occ_wd;
	logic                         act_set;
	logic                         act_clr;
	logic                         pid_we;
	logic [PA_W-1:0]              pid_wa;
	logic [PA_W-1:0]              pid_ra;
	status_t                      status_d;
	logic                         block_d;
	logic                         wake_d;

	status_t             status_s2;
	logic [SEM_W-1:0]    created_s2;
	logic                block_s2;
	logic                wake_s2;
	logic [PID_BITS-1:0] pid_rd_s2;

	logic                rsp_valid_q;
	status_t             status_q;
	logic [IDX_W-1:0]    created_q;
	logic                block_q;
	logic                wake_q;
	logic [PID_BITS-1:0] woken_q;
	logic                rsp_load;

	assign req.ready = (state_q == S_IDLE);
	assign acc       = req.valid && req.ready;
	assign idx_ext   = AW'(req.sem_index);
	assign addr_in   = idx_ext[SEM_W-1:0];
	assign in_range  = idx_ext < AW'(NUM_SEMS);

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1     <= mode_t'(req.mode);
			addr_s1     <= addr_in;
			in_range_s1 <= in_range;
			pid_s1      <= req.caller_pid;
			init_s1     <= req.initial_count;
			count_s1    <= count_mem[addr_in];
			occ_s1      <= occ_mem[addr_in];
			occ_vld_s1  <= occ_vld_q[addr_in];
		end
	end

	always_comb begin
		row        = occ_vld_s1 ? occ_s1 : '0;
		free_found = 1'b0;
		free_slot  = '0;
		busy_found = 1'b0;
		busy_slot  = '0;
		for (int i = WAITERS_PER_SEM - 1; i >= 0; i--) begin
			if (!row[i]) begin
				free_found = 1'b1;
				free_slot  = SLOT_W'(i);
			end
			if (row[i]) begin
				busy_found = 1'b1;
				busy_slot  = SLOT_W'(i);
			end
		end
		sem_found = 1'b0;
		sem_free  = '0;
		for (int j = NUM_SEMS - 1; j >= 0; j--) begin
			if (!active_q[j]) begin
				sem_found = 1'b1;
				sem_free  = SEM_W'(j);
			end
		end
	end

	assign is_active = in_range_s1 && active_q[addr_s1];
	assign cnt_dec   = (count_s1 != CNT_MIN) ? count_s1 - COUNT_BITS'(1) : count_s1;
	assign cnt_inc   = (count_s1 != CNT_MAX) ? count_s1 + COUNT_BITS'(1) : count_s1;

	always_comb begin
		cnt_we   = 1'b0;
		cnt_wa   = addr_s1;
		cnt_wd   = cnt_dec;
		occ_we   = 1'b0;
		occ_wd   = row;
		act_set  = 1'b0;
		act_clr  = 1'b0;
		pid_we   = 1'b0;
		pid_wa   = PA_W'(addr_s1) * PA_W'(WAITERS_PER_SEM) + PA_W'(free_slot);
		pid_ra   = PA_W'(addr_s1) * PA_W'(WAITERS_PER_SEM) + PA_W'(busy_slot);
		status_d = ST_OK;
		block_d  = 1'b0;
		wake_d   = 1'b0;
		if (mode_s1 == MODE_CREATE) begin
			if (sem_found) begin
				act_set = 1'b1;
				cnt_we  = 1'b1;
				cnt_wa  = sem_free;
				cnt_wd  = COUNT_BITS'(init_s1);
			end else begin
				status_d = ST_NO_FREE;
			end
		end else if (!is_active) begin
			status_d = ST_INACTIVE;
		end else begin
			case (mode_s1)
				MODE_DESTROY: begin
					act_clr = 1'b1;
				end
				MODE_WAIT: begin
					if (cnt_dec[COUNT_BITS-1]) begin
						if (free_found) begin
							cnt_we  = 1'b1;
							occ_we  = 1'b1;
							occ_wd  = row | (WAITERS_PER_SEM'(1) << free_slot);
							pid_we  = 1'b1;
							block_d = 1'b1;
						end else begin
							status_d = ST_FULL;
						end
					end else begin
						cnt_we = 1'b1;
					end
				end
				MODE_SIGNAL: begin
					cnt_we = 1'b1;
					cnt_wd = cnt_inc;
					if (cnt_inc[COUNT_BITS-1] || cnt_inc == '0) begin
						if (busy_found) begin
							occ_we = 1'b1;
							occ_wd = row & ~(WAITERS_PER_SEM'(1) << busy_slot);
							wake_d = 1'b1;
						end else begin
							status_d = ST_NO_WAITER;
						end
					end
				end
				default: begin
					status_d = ST_INACTIVE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EVAL) begin
			if (cnt_we) begin
				count_mem[cnt_wa] <= cnt_wd;
			end
			if (occ_we) begin
				occ_mem[addr_s1] <= occ_wd;
			end
			if (pid_we) begin
				pid_mem[pid_wa] <= pid_s1;
			end
			pid_rd_s2  <= pid_mem[pid_ra];
			status_s2  <= status_d;
			created_s2 <= (status_d == ST_OK && mode_s1 == MODE_CREATE) ? sem_free : '0;
			block_s2   <= block_d;
			wake_s2    <= wake_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			occ_vld_q <= '0;
		end else if (state_q == S_EVAL) begin
			if (act_set) begin
				active_q[sem_free] <= 1'b1;
			end
			if (act_clr) begin
				active_q[addr_s1] <= 1'b0;
			end
			if (occ_we) begin
				occ_vld_q[addr_s1] <= 1'b1;
			end
		end
	end

	assign rsp_load = (state_q == S_OUT) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q  <= status_s2;
			created_q <= IDX_W'(created_s2);
			block_q   <= block_s2;
			wake_q    <= wake_s2;
			woken_q   <= wake_s2 ? pid_rd_s2 : '0;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.created_index = created_q;
	assign rsp.must_block    = block_q;
	assign rsp.wake_valid    = wake_q;
	assign rsp.woken_pid     = woken_q;

	a_accept_eval: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == S_EVAL)
		else $error("accepted request did not enter evaluation");

	a_fail_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> !rsp.must_block && !rsp.wake_valid)
		else $error("failing response carries block or wake");

	a_block_wake_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.must_block && rsp.wake_valid))
		else $error("response both blocks and wakes");

	a_slot_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) && pid_we |=> occ_vld_q[$past(addr_s1)])
		else $error("queued waiter row not marked valid");

endmodule
